>>> hdl/mrta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrta_pkg: shared definitions for the mixed-radix time accumulator
// Field widths, moduli, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package mrta_pkg;

  localparam int unsigned FRAME_RATE = 30;
  localparam int unsigned SEC_RATE   = 60;
  localparam int unsigned MIN_RATE   = 60;
  localparam int unsigned HOUR_LIMIT = 99;

  localparam int unsigned NUM_FIELDS = 4;
  localparam int unsigned IDX_W      = $clog2(NUM_FIELDS);
  localparam int unsigned DELTA_W    = 8;
  localparam int unsigned FIELD_W    = 8;
  localparam int unsigned WRAP_W     = 16;

  localparam int unsigned MASK_W     = NUM_FIELDS;
  localparam int unsigned FRAMES_W   = 5;
  localparam int unsigned SECONDS_W  = 6;
  localparam int unsigned MINUTES_W  = 6;
  localparam int unsigned HOURS_W    = 7;

  localparam logic [IDX_W-1:0] IDX_FRAMES  = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_SECONDS = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_MINUTES = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_HOURS   = IDX_W'(3);

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [FIELD_W-1:0] field_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_NORM,
    ST_EMIT
  } mrta_state_e;

  typedef struct packed {
    logic in_rdy;
    logic sum;
    logic step;
    logic rotate;
    logic emit;
  } mrta_cmd_t;

  typedef struct packed {
    logic in_take;
    logic in_range;
    logic last;
    logic out_free;
  } mrta_sts_t;

  function automatic field_t field_mod(input idx_t idx);
    field_t m;
    case (idx)
      IDX_FRAMES:  m = FIELD_W'(FRAME_RATE);
      IDX_SECONDS: m = FIELD_W'(SEC_RATE);
      IDX_MINUTES: m = FIELD_W'(MIN_RATE);
      IDX_HOURS:   m = FIELD_W'(HOUR_LIMIT);
      default:     m = FIELD_W'(FRAME_RATE);
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> hdl/mrta_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrta_in_if / mrta_out_if: valid/ready channels of the time accumulator
// Input carries the four signed deltas, output the mask and updated time.
// ----------------------------------------------------------------------------
interface mrta_in_if;
  import mrta_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DELTA_W-1:0] delta_frames;
  logic signed [DELTA_W-1:0] delta_seconds;
  logic signed [DELTA_W-1:0] delta_minutes;
  logic signed [DELTA_W-1:0] delta_hours;

  modport source (output valid, delta_frames, delta_seconds, delta_minutes, delta_hours,
                  input ready);
  modport sink   (input valid, delta_frames, delta_seconds, delta_minutes, delta_hours,
                  output ready);
endinterface

interface mrta_out_if;
  import mrta_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MASK_W-1:0]    carry_mask;
  logic [FRAMES_W-1:0]  frames_now;
  logic [SECONDS_W-1:0] seconds_now;
  logic [MINUTES_W-1:0] minutes_now;
  logic [HOURS_W-1:0]   hours_now;
  logic [WRAP_W-1:0]    hour_wraps_now;

  modport source (output valid, carry_mask, frames_now, seconds_now, minutes_now,
                  hours_now, hour_wraps_now, input ready);
  modport sink   (input valid, carry_mask, frames_now, seconds_now, minutes_now,
                  hours_now, hour_wraps_now, output ready);
endinterface
`default_nettype wire

>>> hdl/mrta_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrta_ctrl: sequencer of the time accumulator
// Walks the fields in order: sum, normalise one step a cycle, rotate, emit.
// ----------------------------------------------------------------------------
module mrta_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mrta_pkg::mrta_sts_t sts_i,
  output mrta_pkg::mrta_cmd_t cmd_o
);
  import mrta_pkg::*;

  mrta_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.in_take) state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_NORM;
      end
      ST_NORM: begin
        if (sts_i.in_range) state_d = sts_i.last ? ST_EMIT : ST_SUM;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_rdy = 1'b1;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
      end
      ST_NORM: begin
        cmd_o.step   = !sts_i.in_range;
        cmd_o.rotate = sts_i.in_range;
      end
      ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/mrta_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrta_dp: datapath of the time accumulator
// Field ring (current field at slot 0), working sum, hour-wrap count,
// carry mask and the output register.
// ----------------------------------------------------------------------------
module mrta_dp (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mrta_pkg::mrta_cmd_t cmd_i,
  output mrta_pkg::mrta_sts_t sts_o,
  mrta_in_if.sink             in_i,
  mrta_out_if.source          out_o
);
  import mrta_pkg::*;

  field_t            fld_q   [NUM_FIELDS];
  field_t            delta_q [NUM_FIELDS];
  field_t            acc_q;
  idx_t              idx_q;
  logic [MASK_W-1:0] mask_q;
  logic [WRAP_W-1:0] wrap_q;
  logic              out_valid_q;

  logic [MASK_W-1:0]    omask_q;
  logic [FRAMES_W-1:0]  ofrm_q;
  logic [SECONDS_W-1:0] osec_q;
  logic [MINUTES_W-1:0] omin_q;
  logic [HOURS_W-1:0]   ohr_q;
  logic [WRAP_W-1:0]    owrap_q;

  field_t mod;
  logic   neg;
  logic   last;

  assign mod  = field_mod(idx_q);
  assign neg  = acc_q[FIELD_W-1];
  assign last = (idx_q == IDX_HOURS);

  assign in_i.ready     = cmd_i.in_rdy;
  assign sts_o.in_take  = in_i.valid && cmd_i.in_rdy;
  assign sts_o.in_range = !neg && (acc_q < mod);
  assign sts_o.last     = last;
  assign sts_o.out_free = !out_valid_q || out_o.ready;

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (sts_o.in_take) begin
      delta_q[0] <= $unsigned(in_i.delta_frames);
      delta_q[1] <= $unsigned(in_i.delta_seconds);
      delta_q[2] <= $unsigned(in_i.delta_minutes);
      delta_q[3] <= $unsigned(in_i.delta_hours);
    end else if (cmd_i.rotate) begin
      for (int i = 0; i < NUM_FIELDS - 1; i++) delta_q[i] <= delta_q[i+1];
      delta_q[NUM_FIELDS-1] <= delta_q[0];
    end
    if (cmd_i.sum) begin
      acc_q <= fld_q[0] + delta_q[0];
    end else if (cmd_i.step) begin
      acc_q <= neg ? acc_q + mod : acc_q - mod;
    end
    if (cmd_i.emit) begin
      omask_q <= mask_q;
      ofrm_q  <= fld_q[0][FRAMES_W-1:0];
      osec_q  <= fld_q[1][SECONDS_W-1:0];
      omin_q  <= fld_q[2][MINUTES_W-1:0];
      ohr_q   <= fld_q[3][HOURS_W-1:0];
      owrap_q <= wrap_q;
    end
  end

  // time state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FIELDS; i++) fld_q[i] <= '0;
      wrap_q      <= '0;
      idx_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (sts_o.in_take) begin
        idx_q  <= '0;
        mask_q <= '0;
      end
      if (cmd_i.step) begin
        mask_q[idx_q] <= 1'b1;
        if (last) begin
          wrap_q <= neg ? wrap_q - WRAP_W'(1) : wrap_q + WRAP_W'(1);
        end else begin
          fld_q[1] <= neg ? fld_q[1] - FIELD_W'(1) : fld_q[1] + FIELD_W'(1);
        end
      end
      if (cmd_i.rotate) begin
        for (int i = 0; i < NUM_FIELDS - 1; i++) fld_q[i] <= fld_q[i+1];
        fld_q[NUM_FIELDS-1] <= acc_q;
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.carry_mask     = omask_q;
  assign out_o.frames_now     = ofrm_q;
  assign out_o.seconds_now    = osec_q;
  assign out_o.minutes_now    = omin_q;
  assign out_o.hours_now      = ohr_q;
  assign out_o.hour_wraps_now = owrap_q;

endmodule
`default_nettype wire

>>> hdl/mixed_radix_time_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mixed_radix_time_accumulator: running frames:seconds:minutes:hours time
// Each transfer adds four signed deltas and returns the updated time, the
// hour-wrap count and a mask of the fields that carried or borrowed.
// ----------------------------------------------------------------------------
// One item is handled at a time: the item is taken, each field in turn is summed,
// normalised and rotated out, and the result is emitted. Normalisation uses one
// shared add/subtract unit that moves a field sum by one modulus per cycle and
// moves the next field (or the hour-wrap count) by one. With the default moduli
// and an in-range time there are at most 13 normalisation steps per item. The
// result sits in an output register; the next input is taken while it waits.
// ----------------------------------------------------------------------------
module mixed_radix_time_accumulator (
  input  wire        clk_i,
  input  wire        rst_ni,
  mrta_in_if.sink    in_i,
  mrta_out_if.source out_o
);
  import mrta_pkg::*;

  mrta_cmd_t cmd;
  mrta_sts_t sts;

  mrta_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  mrta_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire
